>>> rtl/sha1_pkg.sv
// Shared types, constants and helpers for the SHA-1 hash engine.
// Used by every module under rtl; depends on nothing else.
package sha1_pkg;

   localparam logic [31:0] K_R00 = 32'h5A827999;
   localparam logic [31:0] K_R20 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R40 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R60 = 32'hCA62C1D6;

   localparam logic [31:0] H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [6:0] ROUND_DONE    = 7'd80;
   localparam logic [5:0] LEN_POS       = 6'd56;
   localparam logic [7:0] PAD_BYTE      = 8'h80;
   localparam logic [2:0] MAX_BYTES     = 3'd4;
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;
   localparam logic [6:0] BLOCK_BYTES   = 7'd64;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } sha1_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_result;
   } sha1_rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } sha1_work_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_DATA,
      WR_PAD,
      WR_FILL
   } sha1_wr_mode_type;

   typedef struct packed {
      sha1_wr_mode_type mode;
      logic [5:0]       pos;
      logic [2:0]       take;
      logic [31:0]      data;
      logic [63:0]      length;
      logic             shift;
   } sha1_blk_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_ROUNDS,
      ST_PAD,
      ST_PAD2,
      ST_OUT
   } sha1_state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      return (v << s) | (v >> (6'd32 - {1'b0, s}));
   endfunction

endpackage

>>> rtl/sha1_hash_engine_core.sv
// Top level of the streaming SHA-1 hash engine: sequencer, chaining state and output register.
// Depends on sha1_pkg, sha1_round and sha1_sched.
//
// Usage: each request on the req_ channel carries up to four big-endian message bytes,
// a count of valid leading bytes (values above four count as four) and a last-word mark.
// A request is taken when req_valid is high and req_stall is low; req_stall is high
// whenever the sequencer is busy. A request that does not complete a 64-byte block is
// absorbed in its accept cycle. A request that completes a block is followed by the compression
// (all rounds on the one shared round unit, then the chaining add) and then an absorb step for
// any bytes left over; req_stall stays high throughout, so no new request is taken until then.
// After a last-word request the engine pads and compresses one or two more blocks before the
// first digest word appears, and first compresses the block that request completes, if any.
// The five digest words, H0 first, leave on the rsp_ channel one per cycle while rsp_stall is
// low, through an output register. When the receiver raises rsp_stall the held word stays put
// and the sequencer waits. After the fifth word is loaded the chaining words and bit length
// return to their initial values and new requests are taken while that word still waits.
// Synchronous reset returns the engine to idle with the initial chaining words, a zero
// bit length and an empty output register.
module sha1_hash_engine_core import sha1_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sha1_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sha1_rsp_type rsp_data
);

   sha1_state_type   state_ff, state_in;
   sha1_state_type   ret_ff, ret_in;
   logic [31:0]      chain_ff [5];
   logic [31:0]      chain_in [5];
   sha1_work_type    work_ff, work_in;
   logic [6:0]       round_ff, round_in;
   logic [63:0]      bitlen_ff, bitlen_in;
   logic [31:0]      hold_data_ff, hold_data_in;
   logic [2:0]       hold_cnt_ff, hold_cnt_in;
   logic             hold_last_ff, hold_last_in;
   logic [2:0]       out_idx_ff, out_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sha1_rsp_type     rsp_data_ff, rsp_data_in;

   sha1_blk_ctl_type blk_ctl;
   sha1_work_type    round_nxt;
   logic [31:0]      w_cur;

   logic [31:0]      src_data;
   logic [2:0]       src_cnt;
   logic             src_last;
   logic [5:0]       pos;
   logic [6:0]       room;
   logic [2:0]       take;
   logic             filled;
   logic             absorb_go;
   logic             out_load;

   sha1_round u_round (
      .cur   (work_ff),
      .wt    (w_cur),
      .round (round_ff),
      .nxt   (round_nxt)
   );

   sha1_sched u_sched (
      .clock (clock),
      .ctl   (blk_ctl),
      .w_cur (w_cur)
   );

   // The byte source is the incoming request in idle and the leftover bytes otherwise.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         src_data = req_data.data_word;
         src_cnt  = (req_data.valid_bytes > MAX_BYTES) ? MAX_BYTES : req_data.valid_bytes;
         src_last = req_data.last_word;
      end else begin
         src_data = hold_data_ff;
         src_cnt  = hold_cnt_ff;
         src_last = hold_last_ff;
      end
   end

   // Bits 8..3 of the bit length give the byte position in the current block.
   assign pos       = bitlen_ff[8:3];
   assign room      = BLOCK_BYTES - {1'b0, pos};
   assign take      = ({4'b0000, src_cnt} < room) ? src_cnt : room[2:0];
   assign filled    = (({1'b0, pos} + {4'b0000, take}) == BLOCK_BYTES);
   assign absorb_go = ((state_ff == ST_IDLE) && req_valid) || (state_ff == ST_ABSORB);
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_ABSORB: begin
            if (absorb_go) begin
               if (filled) begin
                  state_in = ST_ROUNDS;
               end else if (src_last) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROUNDS: begin
            if (round_ff == ROUND_DONE) begin
               state_in = ret_ff;
            end
         end
         ST_PAD, ST_PAD2: begin
            state_in = ST_ROUNDS;
         end
         ST_OUT: begin
            if (out_load && (out_idx_ff == LAST_WORD_IDX)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      blk_ctl.mode   = WR_NONE;
      blk_ctl.pos    = pos;
      blk_ctl.take   = take;
      blk_ctl.data   = src_data;
      blk_ctl.length = bitlen_ff;
      blk_ctl.shift  = 1'b0;

      ret_in       = ret_ff;
      work_in      = work_ff;
      round_in     = round_ff;
      bitlen_in    = bitlen_ff;
      hold_data_in = hold_data_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_last_in = hold_last_ff;
      out_idx_in   = out_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      for (int i = 0; i < 5; i++) begin
         chain_in[i] = chain_ff[i];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE, ST_ABSORB: begin
            if (absorb_go) begin
               blk_ctl.mode = WR_DATA;
               bitlen_in    = bitlen_ff + {58'd0, take, 3'b000};
               hold_data_in = src_data << {take, 3'b000};
               hold_cnt_in  = src_cnt - take;
               hold_last_in = src_last;
               ret_in       = ST_ABSORB;
            end
         end
         ST_ROUNDS: begin
            if (round_ff != ROUND_DONE) begin
               work_in       = round_nxt;
               blk_ctl.shift = 1'b1;
               round_in      = round_ff + 7'd1;
            end else begin
               chain_in[0] = chain_ff[0] + work_ff.a;
               chain_in[1] = chain_ff[1] + work_ff.b;
               chain_in[2] = chain_ff[2] + work_ff.c;
               chain_in[3] = chain_ff[3] + work_ff.d;
               chain_in[4] = chain_ff[4] + work_ff.e;
               round_in    = 7'd0;
            end
         end
         ST_PAD: begin
            // The length fits behind the pad byte only when the pad byte lands before byte 56.
            blk_ctl.mode = WR_PAD;
            ret_in       = (pos < LEN_POS) ? ST_OUT : ST_PAD2;
         end
         ST_PAD2: begin
            blk_ctl.mode = WR_FILL;
            ret_in       = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = chain_ff[out_idx_ff];
               rsp_data_in.word_index  = out_idx_ff;
               rsp_data_in.last_result = (out_idx_ff == LAST_WORD_IDX);
               if (out_idx_ff == LAST_WORD_IDX) begin
                  out_idx_in = 3'd0;
                  bitlen_in  = 64'd0;
                  for (int i = 0; i < 5; i++) begin
                     chain_in[i] = H_INIT[i];
                  end
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            blk_ctl.mode = WR_NONE;
         end
      endcase

      // Every compression starts from the current chaining words.
      if ((state_in == ST_ROUNDS) && (state_ff != ST_ROUNDS)) begin
         work_in.a = chain_ff[0];
         work_in.b = chain_ff[1];
         work_in.c = chain_ff[2];
         work_in.d = chain_ff[3];
         work_in.e = chain_ff[4];
         round_in  = 7'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_ABSORB;
         round_ff     <= 7'd0;
         bitlen_ff    <= 64'd0;
         hold_cnt_ff  <= 3'd0;
         hold_last_ff <= 1'b0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= H_INIT[i];
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         bitlen_ff    <= bitlen_in;
         hold_cnt_ff  <= hold_cnt_in;
         hold_last_ff <= hold_last_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      hold_data_ff <= hold_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/sha1_round.sv
// One SHA-1 round: round function, round constant and the five-word update.
// Depends on sha1_pkg.
module sha1_round import sha1_pkg::*; (
   input  sha1_work_type cur,
   input  logic [31:0]   wt,
   input  logic [6:0]    round,
   output sha1_work_type nxt
);

   logic [31:0] f;
   logic [31:0] k;

   always_comb begin
      if (round < 7'd20) begin
         f = (cur.b & cur.c) | (~cur.b & cur.d);
         k = K_R00;
      end else if (round < 7'd40) begin
         f = cur.b ^ cur.c ^ cur.d;
         k = K_R20;
      end else if (round < 7'd60) begin
         f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k = K_R40;
      end else begin
         f = cur.b ^ cur.c ^ cur.d;
         k = K_R60;
      end
   end

   always_comb begin
      nxt.a = rotl32(cur.a, 5'd5) + f + cur.e + k + wt;
      nxt.b = cur.a;
      nxt.c = rotl32(cur.b, 5'd30);
      nxt.d = cur.c;
      nxt.e = cur.d;
   end

endmodule

>>> rtl/sha1_sched.sv
// Message block store that doubles as the 16-word message schedule.
// Takes byte writes for data and padding, and shifts one word per round. Depends on sha1_pkg.
module sha1_sched import sha1_pkg::*; (
   input  logic             clock,
   input  sha1_blk_ctl_type ctl,
   output logic [31:0]      w_cur
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] fb;

   assign fb = rotl32(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 5'd1);

   always_comb begin
      logic [5:0] jj;
      logic [5:0] off;
      logic       en;
      logic [7:0] bval;
      int         lb;
      for (int k = 0; k < 16; k++) begin
         w_in[k] = w_ff[k];
      end
      if (ctl.shift) begin
         for (int k = 0; k < 15; k++) begin
            w_in[k] = w_ff[k + 1];
         end
         w_in[15] = fb;
      end else begin
         for (int j = 0; j < 64; j++) begin
            jj   = 6'(j);
            off  = jj - ctl.pos;
            lb   = (j >= 56) ? (j - 56) : 0;
            en   = 1'b0;
            bval = 8'h00;
            case (ctl.mode)
               WR_DATA: begin
                  en   = (jj >= ctl.pos) && (off < {3'b000, ctl.take});
                  bval = ctl.data[31 - 8 * int'(off[1:0]) -: 8];
               end
               WR_PAD: begin
                  en = (jj >= ctl.pos);
                  if (jj == ctl.pos) begin
                     bval = PAD_BYTE;
                  end else if ((ctl.pos < LEN_POS) && (jj >= LEN_POS)) begin
                     bval = ctl.length[63 - 8 * lb -: 8];
                  end
               end
               WR_FILL: begin
                  en = 1'b1;
                  if (jj >= LEN_POS) begin
                     bval = ctl.length[63 - 8 * lb -: 8];
                  end
               end
               default: begin
                  en = 1'b0;
               end
            endcase
            if (en) begin
               w_in[j >> 2][31 - 8 * (j & 3) -: 8] = bval;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 16; k++) begin
         w_ff[k] <= w_in[k];
      end
   end

   assign w_cur = w_ff[0];

endmodule
